// ----- sv/cerq_pkg.sv -----
// ----------------------------------------------------------------------------
// cerq_pkg
// Shared types and constants for the coalescing event ring queue.
// ----------------------------------------------------------------------------
package cerq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 128;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int VAL_W    = 32;
    localparam int EXTRA_W  = 16;
    localparam int FILL_W   = 8;

    // Operation codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        KIND_MOVE   = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_BUTTON = 2'd2,
        KIND_OTHER  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_POPPED   = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // One queue entry as stored in the RAM
    typedef struct packed {
        kind_t                    kind;
        logic signed [VAL_W-1:0]  first;
        logic signed [VAL_W-1:0]  second;
        logic [EXTRA_W-1:0]       extra;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // latch item, issue RAM read
        logic commit;   // update queue, load result register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free; // result register can take a new item
    } dp_status_t;

endpackage

// ----- sv/cerq_ram.sv -----
// ----------------------------------------------------------------------------
// cerq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cerq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/cerq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cerq_ctrl
// Sequencer: accept an item, then commit it once the result register is free.
// ----------------------------------------------------------------------------
module cerq_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  cerq_pkg::dp_status_t   dp_st,
    output cerq_pkg::ctrl_cmd_t    cmd
);
    import cerq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (dp_st.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ----- sv/cerq_dp.sv -----
// ----------------------------------------------------------------------------
// cerq_dp
// Datapath: entry RAM, ring pointers, fill count, merge adders, result register.
// ----------------------------------------------------------------------------
module cerq_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  cerq_pkg::ctrl_cmd_t                  cmd,
    output cerq_pkg::dp_status_t                 dp_st,
    // item fields
    input  logic                                 in_func,
    input  cerq_pkg::kind_t                      in_kind,
    input  logic signed [cerq_pkg::VAL_W-1:0]    in_first,
    input  logic signed [cerq_pkg::VAL_W-1:0]    in_second,
    input  logic [cerq_pkg::EXTRA_W-1:0]         in_extra,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data,
    // result
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output cerq_pkg::status_t                    out_status,
    output cerq_pkg::kind_t                      out_kind,
    output logic signed [cerq_pkg::VAL_W-1:0]    out_first,
    output logic signed [cerq_pkg::VAL_W-1:0]    out_second,
    output logic [cerq_pkg::EXTRA_W-1:0]         out_extra,
    output logic [cerq_pkg::FILL_W-1:0]          out_fill
);
    import cerq_pkg::*;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    // Control state
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             mouse_reg;
    logic             valid_reg;

    // Latched item
    logic                     func_reg;
    kind_t                    kind_reg;
    logic signed [VAL_W-1:0]  first_reg;
    logic signed [VAL_W-1:0]  second_reg;
    logic [EXTRA_W-1:0]       extra_reg;

    // Result register
    status_t                  status_reg, status_next;
    kind_t                    okind_reg,  okind_next;
    logic signed [VAL_W-1:0]  ofirst_reg, ofirst_next;
    logic signed [VAL_W-1:0]  osecond_reg, osecond_next;
    logic [EXTRA_W-1:0]       oextra_reg, oextra_next;
    logic [FILL_W-1:0]        fill_reg;

    // RAM ports
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [PTR_W-1:0] ram_raddr;
    entry_t           ram_rdata;
    logic             merge_move;
    logic             merge_scroll;

    cerq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.load),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pop reads the oldest entry, push reads the newest for a possible merge
    assign ram_raddr = (in_func == FUNC_POP) ? rd_ptr_reg : ring_prev(wr_ptr_reg);

    // Merge detection against the newest entry
    always_comb begin
        merge_move   = 1'b0;
        merge_scroll = 1'b0;
        if (func_reg == FUNC_PUSH && mouse_reg && count_reg != '0) begin
            merge_move   = (ram_rdata.kind == KIND_MOVE)   && (kind_reg == KIND_MOVE);
            merge_scroll = (ram_rdata.kind == KIND_SCROLL) && (kind_reg == KIND_SCROLL);
        end
    end

    // Queue update for the latched item
    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        count_next   = count_reg;
        ram_we       = 1'b0;
        ram_waddr    = wr_ptr_reg;
        ram_wdata    = '{kind: kind_reg, first: first_reg, second: second_reg,
                         extra: extra_reg};
        status_next  = ST_APPENDED;
        okind_next   = KIND_MOVE;
        ofirst_next  = '0;
        osecond_next = '0;
        oextra_next  = '0;
        if (func_reg == FUNC_PUSH) begin
            if (merge_move || merge_scroll) begin
                // add into the newest entry in place
                ram_we           = cmd.commit;
                ram_waddr        = ring_prev(wr_ptr_reg);
                ram_wdata        = ram_rdata;
                ram_wdata.first  = ram_rdata.first + first_reg;
                if (merge_move) begin
                    ram_wdata.second = ram_rdata.second + second_reg;
                end
                status_next      = ST_MERGED;
            end else begin
                ram_we      = cmd.commit;
                wr_ptr_next = ring_next(wr_ptr_reg);
                if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                    // full: oldest entry is dropped, count stays
                    rd_ptr_next = ring_next(rd_ptr_reg);
                    status_next = ST_DROPPED;
                end else begin
                    count_next  = count_reg + 1'b1;
                end
            end
        end else if (count_reg == '0) begin
            status_next = ST_EMPTY;
        end else begin
            status_next  = ST_POPPED;
            okind_next   = ram_rdata.kind;
            ofirst_next  = ram_rdata.first;
            osecond_next = ram_rdata.second;
            oextra_next  = ram_rdata.extra;
            rd_ptr_next  = ring_next(rd_ptr_reg);
            count_next   = count_reg - 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            mouse_reg  <= 1'b1;
            valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mouse_reg <= cfg_data;
            end
            if (cmd.commit) begin
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
                count_reg  <= count_next;
                valid_reg  <= 1'b1;
            end else if (out_ready) begin
                valid_reg  <= 1'b0;
            end
        end
    end

    // Item latch and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg   <= in_func;
            kind_reg   <= in_kind;
            first_reg  <= in_first;
            second_reg <= in_second;
            extra_reg  <= in_extra;
        end
        if (cmd.commit) begin
            status_reg  <= status_next;
            okind_reg   <= okind_next;
            ofirst_reg  <= ofirst_next;
            osecond_reg <= osecond_next;
            oextra_reg  <= oextra_next;
            fill_reg    <= FILL_W'(count_next);
        end
    end

    assign dp_st.out_free = !valid_reg || out_ready;
    assign cfg_ready      = 1'b1;
    assign out_valid      = valid_reg;
    assign out_status     = status_reg;
    assign out_kind       = okind_reg;
    assign out_first      = ofirst_reg;
    assign out_second     = osecond_reg;
    assign out_extra      = oextra_reg;
    assign out_fill       = fill_reg;

endmodule

// ----- sv/coalescing_event_ring_queue.sv -----
// ----------------------------------------------------------------------------
// coalescing_event_ring_queue
// Input event ring queue with move and scroll coalescing in mouse mode.
// ----------------------------------------------------------------------------
// Each item is a push or a pop and yields exactly one result item. An item
// passes a read step, reading the entry RAM through its registered read port
// (the oldest entry for a pop, the newest for a possible merge on a push), and
// a commit step, updating the RAM, the pointers and the fill count and loading
// the result register. s_tready rises again in the cycle after the commit, so
// a new item is taken only once the last one is committed; a stalled result
// holds the commit step until the result register frees. Entry storage needs
// no clearing after reset: only entries within the fill count are ever used.
module coalescing_event_ring_queue (
    input  logic        aclk,
    input  logic        aresetn,
    // item in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // first_value[31:0], second_value[63:32], extra_data[79:64]
    input  logic [2:0]  s_tuser,  // func[0], event_kind[2:1]
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data, // device_is_mouse
    // result out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,  // out_first[31:0], out_second[63:32], out_extra[79:64],
                                  // fill_level[87:80]
    output logic [4:0]  m_tuser   // status[2:0], out_kind[4:3]
);
    import cerq_pkg::*;

    ctrl_cmd_t               cmd;
    dp_status_t              dp_st;
    status_t                 out_status;
    kind_t                   out_kind;
    logic signed [VAL_W-1:0] out_first;
    logic signed [VAL_W-1:0] out_second;
    logic [EXTRA_W-1:0]      out_extra;
    logic [FILL_W-1:0]       out_fill;

    cerq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_st    (dp_st),
        .cmd      (cmd)
    );

    cerq_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .dp_st      (dp_st),
        .in_func    (s_tuser[0]),
        .in_kind    (kind_t'(s_tuser[2:1])),
        .in_first   (s_tdata[31:0]),
        .in_second  (s_tdata[63:32]),
        .in_extra   (s_tdata[79:64]),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_kind   (out_kind),
        .out_first  (out_first),
        .out_second (out_second),
        .out_extra  (out_extra),
        .out_fill   (out_fill)
    );

    // Result packing
    assign m_tdata = {out_fill, out_extra, out_second, out_first};
    assign m_tuser = {out_kind, out_status};

`ifndef ASSERT_OFF
    // A committed item always shows up as a result
    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("commit did not produce a result");

    // No new item is taken while one is in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_tready)
        else $error("item accepted while another is in flight");

    // Fill level never exceeds the queue depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_fill <= FILL_W'(QUEUE_DEPTH)))
        else $error("fill level beyond queue depth");

    // Empty status means an empty queue and a result that carries no entry
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_status == ST_EMPTY) |-> (out_fill == '0 && out_first == '0))
        else $error("empty result with nonzero fields");
`endif

endmodule
